@@ design/hll_pkg.sv @@
// shared types and constants for the hyperloglog sketch
`timescale 1ns / 1ps
package hll_pkg;
  localparam int REG_COUNT_DEF = 64;
  localparam int HASH_BITS_DEF = 32;
  localparam int SUM_FRAC = 27;
  localparam logic [15:0] ALPHA_RESET = 16'd46465;
  localparam logic [31:0] LN2_Q32 = 32'd2977044472;
  localparam logic [1:0] REQ_ADD = 2'd0;
  localparam logic [1:0] REQ_MERGE = 2'd1;
  localparam logic [1:0] REQ_QUERY = 2'd2;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_WRITE, ST_DIV, ST_LGZ, ST_LOG, ST_MUL, ST_FIN, ST_OUT
  } state_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic div_start;
    logic lg_start;
    logic lg2_start;
    logic mul;
    logic fin;
    logic out_load;
    logic cap;
  } cmd_t;

  typedef struct packed {
    logic is_query;
    logic is_nop;
    logic div_done;
    logic lg_done;
    logic need_lg;
    logic need_lgz;
  } sts_t;
endpackage

@@ design/hll_ctrl.sv @@
// sequencer for register updates and estimate queries
`timescale 1ns / 1ps
module hll_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  output logic          out_valid,
  input  logic          out_stall,
  input  hll_pkg::sts_t sts,
  output hll_pkg::cmd_t cmd
);
  import hll_pkg::*;
  state_t st_r, st_nxt;
  logic ov_r, ov_nxt;
  logic lgz_r, lgz_nxt;

  assign in_stall = (st_r != ST_IDLE) || (ov_r && out_stall);
  assign out_valid = ov_r;

  always_comb begin
    st_nxt = st_r;
    lgz_nxt = lgz_r;
    unique case (st_r)
      ST_IDLE: if (in_valid && !in_stall) st_nxt = ST_READ;
      ST_READ: begin
        if (sts.is_query) st_nxt = ST_DIV;
        else if (sts.is_nop) st_nxt = ST_OUT;
        else st_nxt = ST_WRITE;
      end
      ST_WRITE: st_nxt = ST_OUT;
      ST_DIV: if (sts.div_done) begin
        lgz_nxt = sts.need_lgz;
        st_nxt = sts.need_lg ? ST_LOG : ST_FIN;
      end
      ST_LOG: if (sts.lg_done) st_nxt = lgz_r ? ST_LGZ : ST_MUL;
      ST_LGZ: if (sts.lg_done) begin
        lgz_nxt = 1'b0;
        st_nxt = ST_MUL;
      end
      ST_MUL: st_nxt = ST_FIN;
      ST_FIN: st_nxt = ST_OUT;
      ST_OUT: if (!ov_r || !out_stall) st_nxt = ST_IDLE;
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd = '0;
    ov_nxt = ov_r && out_stall;
    unique case (st_r)
      ST_IDLE: cmd.cap = in_valid && !in_stall;
      ST_READ: begin
        cmd.rd = 1'b1;
        cmd.div_start = sts.is_query;
      end
      ST_WRITE: cmd.wr = 1'b1;
      ST_DIV: cmd.lg_start = sts.div_done && sts.need_lg;
      ST_LOG: cmd.lg2_start = sts.lg_done && lgz_r;
      ST_LGZ: ;
      ST_MUL: cmd.mul = 1'b1;
      ST_FIN: cmd.fin = 1'b1;
      ST_OUT: if (!ov_r || !out_stall) begin
        cmd.out_load = 1'b1;
        ov_nxt = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      ov_r <= 1'b0;
      lgz_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      ov_r <= ov_nxt;
      lgz_r <= lgz_nxt;
    end
  end
endmodule

@@ design/hll_dp.sv @@
// sketch registers, running sum and estimate arithmetic
`timescale 1ns / 1ps
module hll_dp #(
  parameter int REGISTER_COUNT = hll_pkg::REG_COUNT_DEF,
  parameter int HASH_BITS = hll_pkg::HASH_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          cfg_write,
  input  logic [15:0]   cfg_data,
  input  logic [1:0]    in_req_type,
  input  logic [31:0]   in_hash_value,
  input  logic [5:0]    in_merge_index,
  input  logic [4:0]    in_merge_rank,
  input  hll_pkg::cmd_t cmd,
  output hll_pkg::sts_t sts,
  output logic [31:0]   out_estimate,
  output logic          out_saturated,
  output logic          out_register_raised
);
  import hll_pkg::*;
  localparam int B = $clog2(REGISTER_COUNT + 1) - 1;
  localparam int L = HASH_BITS - B;
  localparam int IW = (B > 6) ? B : 6;
  localparam int CW = $clog2(REGISTER_COUNT + 1);
  localparam int SW = SUM_FRAC + CW;
  localparam logic [SW-1:0] SUM_RESET = SW'(REGISTER_COUNT) << SUM_FRAC;
  localparam logic [63:0] M64 = 64'(REGISTER_COUNT);
  localparam logic [63:0] SMALL_LIM = 64'(5 * REGISTER_COUNT) << 15;
  localparam logic [63:0] LARGE_LIM = (64'd1 << 48) / 30;

  logic [4:0] mem [REGISTER_COUNT];
  logic [REGISTER_COUNT-1:0] vld_r;
  logic [15:0] alpha_r;
  logic [SW-1:0] sum_r;
  logic [CW-1:0] zc_r;
  logic [1:0] req_r;
  logic [IW-1:0] idx_r;
  logic [4:0] rank_r;
  logic ok_r;
  logic raised_r;

  // rank of an add
  logic [31:0] rest;
  logic [5:0] lz;
  always_comb begin
    rest = in_hash_value << B;
    lz = 6'd32;
    for (int i = 0; i < 32; i++) if (rest[i]) lz = 6'(31 - i);
    if (lz > 6'(L)) lz = 6'(L);
  end

  logic [5:0] mr;
  assign mr = (6'(in_merge_rank) > 6'(L + 1)) ? 6'(L + 1) : 6'(in_merge_rank);

  always_ff @(posedge clk) begin
    if (cmd.cap) begin
      req_r <= in_req_type;
      if (in_req_type == REQ_ADD) begin
        idx_r <= IW'(in_hash_value >> L);
        rank_r <= 5'(lz + 6'd1);
        ok_r <= 1'b1;
      end else begin
        idx_r <= IW'(in_merge_index);
        rank_r <= 5'(mr);
        ok_r <= 32'(in_merge_index) < 32'(REGISTER_COUNT);
      end
    end
  end

  logic [B-1:0] ia;
  assign ia = idx_r[B-1:0];
  logic [4:0] old_r;
  always_ff @(posedge clk) if (cmd.rd) old_r <= vld_r[ia] ? mem[ia] : 5'd0;

  function automatic logic [SW-1:0] contrib(input logic [4:0] r);
    return (r <= 5'(SUM_FRAC)) ? (SW'(1) << (SUM_FRAC - r)) : '0;
  endfunction

  logic up;
  assign up = ok_r && (rank_r > old_r);

  always_ff @(posedge clk) begin
    if (cmd.wr && up) mem[ia] <= rank_r;
  end

  assign sts.is_query = (req_r == REQ_QUERY);
  assign sts.is_nop = (req_r != REQ_ADD) && (req_r != REQ_MERGE) && (req_r != REQ_QUERY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
      sum_r <= SUM_RESET;
      zc_r <= CW'(REGISTER_COUNT);
      alpha_r <= ALPHA_RESET;
    end else begin
      if (cfg_write) alpha_r <= cfg_data;
      if (cmd.wr && up) begin
        vld_r[ia] <= 1'b1;
        sum_r <= sum_r - contrib(old_r) + contrib(rank_r);
        if (old_r == 5'd0) zc_r <= zc_r - CW'(1);
      end
    end
  end
  always_ff @(posedge clk) begin
    if (cmd.rd) raised_r <= 1'b0;
    if (cmd.wr) raised_r <= up;
  end

  // restoring divider: numerator alpha*m*m << 59
  logic [95:0] num_r;
  logic [63:0] q_r;
  logic [SW:0] rem_r;
  logic [6:0] dcnt_r;
  logic dbusy_r;
  logic [SW:0] trial;
  assign trial = {rem_r[SW-1:0], num_r[95]};
  always_ff @(posedge clk) begin
    if (!rst_n) dbusy_r <= 1'b0;
    else if (cmd.div_start) begin
      num_r <= (96'(alpha_r) * 96'(REGISTER_COUNT) * 96'(REGISTER_COUNT)) << (SUM_FRAC + 32);
      rem_r <= '0;
      q_r <= '0;
      dcnt_r <= 7'd0;
      dbusy_r <= 1'b1;
    end else if (dbusy_r) begin
      num_r <= num_r << 1;
      if (trial >= {1'b0, sum_r}) begin
        rem_r <= trial - {1'b0, sum_r};
        q_r <= {q_r[62:0], 1'b1};
      end else begin
        rem_r <= trial;
        q_r <= {q_r[62:0], 1'b0};
      end
      dcnt_r <= dcnt_r + 7'd1;
      if (dcnt_r == 7'd63) dbusy_r <= 1'b0;
    end
  end
  logic div_done;
  assign div_done = dbusy_r && (dcnt_r == 7'd63);
  logic [63:0] eq;
  assign eq = {q_r[62:0], trial >= {1'b0, sum_r}};

  // range decision, registered at div end
  logic [1:0] mode_r;
  logic [63:0] eq_r;
  localparam logic [1:0] MD_PLAIN = 2'd0, MD_SMALL = 2'd1, MD_LARGE = 2'd2, MD_SAT = 2'd3;
  logic [1:0] mode_c;
  always_comb begin
    if (sum_r == '0) mode_c = MD_SAT;
    else if (eq <= SMALL_LIM) mode_c = (zc_r != '0) ? MD_SMALL : MD_PLAIN;
    else if (eq > LARGE_LIM) mode_c = (eq >= (64'd1 << 48)) ? MD_SAT : MD_LARGE;
    else mode_c = MD_PLAIN;
  end
  assign sts.div_done = div_done;
  assign sts.need_lg = (mode_c == MD_SMALL) || (mode_c == MD_LARGE);
  assign sts.need_lgz = (mode_c == MD_SMALL);

  // log2 unit, one squaring per cycle
  logic [63:0] y_r;
  logic [63:0] lres_r;
  logic [5:0] lcnt_r;
  logic lbusy_r;
  logic [63:0] lx;
  logic [5:0] ln;
  logic [63:0] lg_a_r;
  logic [63:0] ysq;
  always_comb begin
    if (cmd.lg_start) lx = (mode_c == MD_SMALL) ? M64 : (64'd1 << 48) - eq;
    else lx = 64'(zc_r);
    ln = 6'd0;
    for (int i = 1; i < 64; i++) if (lx[i]) ln = 6'(i);
  end
  assign ysq = (64'(y_r[32:0]) * 64'(y_r[32:0])) >> 31;
  always_ff @(posedge clk) begin
    if (!rst_n) lbusy_r <= 1'b0;
    else if (cmd.lg_start || cmd.lg2_start) begin
      y_r <= (ln <= 6'd31) ? (lx << (6'd31 - ln)) : (lx >> (ln - 6'd31));
      lres_r <= 64'(ln) << 32;
      lcnt_r <= 6'd0;
      lbusy_r <= 1'b1;
    end else if (lbusy_r) begin
      if (ysq >= (64'd1 << 32)) begin
        y_r <= ysq >> 1;
        lres_r[5'd31 - lcnt_r[4:0]] <= 1'b1;
      end else y_r <= ysq;
      lcnt_r <= lcnt_r + 6'd1;
      if (lcnt_r == 6'd31) lbusy_r <= 1'b0;
    end
  end
  logic [63:0] lfin;
  always_comb begin
    lfin = lres_r;
    if (ysq >= (64'd1 << 32)) lfin[0] = 1'b1;
  end
  assign sts.lg_done = lbusy_r && (lcnt_r == 6'd31);

  always_ff @(posedge clk) begin
    if (div_done) begin
      mode_r <= mode_c;
      eq_r <= eq;
    end
    if (sts.lg_done && cmd.lg2_start) lg_a_r <= lfin;
    else if (sts.lg_done && mode_r == MD_SMALL) lg_a_r <= lg_a_r - lfin;
    else if (sts.lg_done) lg_a_r <= (64'd48 << 32) - lfin;
  end

  // d*ln2 >> 32, d below 2^38
  logic [69:0] prod_r;
  logic [63:0] est_c;
  logic [32:0] est_r;
  always_ff @(posedge clk) begin
    if (cmd.mul) prod_r <= (70'(lg_a_r[37:0]) * 70'(LN2_Q32));
  end
  always_comb begin
    if (mode_r == MD_SMALL) est_c = (M64 * 64'(prod_r[69:32])) >> 32;
    else if (mode_r == MD_LARGE) est_c = 64'(prod_r[69:32]);
    else est_c = eq_r >> 16;
  end
  always_ff @(posedge clk) begin
    if (cmd.rd) est_r <= '0;
    if (cmd.fin) est_r <= (mode_r == MD_SAT || est_c > 64'hFFFF_FFFF) ? 33'h1_FFFF_FFFF
                                                                      : {1'b0, est_c[31:0]};
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_estimate <= est_r[31:0];
      out_saturated <= est_r[32];
      out_register_raised <= raised_r;
    end
  end
endmodule

@@ design/hyperloglog_cardinality_sketch_top.sv @@
// top level of the hyperloglog cardinality sketch
// add or merge: the rank register is read, then written, then the result goes to the output register
// query: 64-step divider, then no log squaring run in plain range, one 32-step run
//   in large range and two in small range
// one request at a time; result held in an output register until taken
// synchronous active-low reset clears all rank registers at once via valid bits
`timescale 1ns / 1ps
module hyperloglog_cardinality_sketch_top #(
  parameter int REGISTER_COUNT = hll_pkg::REG_COUNT_DEF,
  parameter int HASH_BITS = hll_pkg::HASH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_write,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_req_type,
  input  logic [31:0] in_hash_value,
  input  logic [5:0]  in_merge_index,
  input  logic [4:0]  in_merge_rank,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] out_estimate,
  output logic        out_saturated,
  output logic        out_register_raised
);
  import hll_pkg::*;
  cmd_t cmd;
  sts_t sts;
  hll_ctrl u_ctrl (.clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd);
  hll_dp #(.REGISTER_COUNT(REGISTER_COUNT), .HASH_BITS(HASH_BITS)) u_dp (
    .clk, .rst_n, .cfg_write, .cfg_data, .in_req_type, .in_hash_value, .in_merge_index,
    .in_merge_rank, .cmd, .sts, .out_estimate, .out_saturated, .out_register_raised);
endmodule

@@ design/hll_chk.sv @@
// port-level checks for the sketch top level
`timescale 1ns / 1ps
module hll_chk (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic [31:0] out_estimate,
  input logic out_saturated,
  input logic out_register_raised
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_estimate)) else $error("out hold");
  a_one: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall) else $error("second request taken");
  a_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_saturated |-> out_estimate == 32'hFFFF_FFFF) else $error("sat value");
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_register_raised |-> out_estimate == 32'd0) else $error("raised est");
endmodule

bind hyperloglog_cardinality_sketch_top hll_chk u_chk (.clk, .rst_n, .in_valid, .in_stall,
  .out_valid, .out_stall, .out_estimate, .out_saturated, .out_register_raised);
